// ===== rtl/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg
// shared types and codes of the stack machine alu
// ----------------------------------------------------------------------------
`default_nettype none

package sma_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [2:0] cmd_t;
  typedef logic [2:0] status_t;

  // command codes
  localparam cmd_t CMD_PUSH    = 3'd0;
  localparam cmd_t CMD_POP     = 3'd1;
  localparam cmd_t CMD_ADD     = 3'd2;
  localparam cmd_t CMD_SUB     = 3'd3;
  localparam cmd_t CMD_MUL     = 3'd4;
  localparam cmd_t CMD_DIV     = 3'd5;
  localparam cmd_t CMD_MOV     = 3'd6;
  localparam cmd_t CMD_UNKNOWN = 3'd7;

  // status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_UNDERFLOW = 3'd1;
  localparam status_t ST_OVERFLOW  = 3'd2;
  localparam status_t ST_DIVZERO   = 3'd3;
  localparam status_t ST_UNKNOWN   = 3'd4;

  // divider request and response
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/sma_stack_mem.sv =====
// ----------------------------------------------------------------------------
// sma_stack_mem
// operand stack storage, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sma_stack_mem #(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire sma_pkg::word_t           wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output sma_pkg::word_t                rdata
);
  import sma_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/sma_div.sv =====
// ----------------------------------------------------------------------------
// sma_div
// signed divider, truncating toward zero, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sma_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sma_pkg::div_req_t req,
  output sma_pkg::div_rsp_t      rsp
);
  import sma_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_W - 1);

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [WORD_W-1:0]   rem;
  logic [WORD_W-1:0]   quo;
  logic [WORD_W-1:0]   mag_b;
  logic                neg;
  logic [WORD_W:0]     rem_sh;
  logic [WORD_W:0]     diff;
  logic [WORD_W-1:0]   mag_a_in;
  logic [WORD_W-1:0]   mag_b_in;

  assign mag_a_in = req.dividend[WORD_W-1] ? (WORD_W'(0) - req.dividend) : req.dividend;
  assign mag_b_in = req.divisor[WORD_W-1]  ? (WORD_W'(0) - req.divisor)  : req.divisor;

  // restoring step
  assign rem_sh = {rem, quo[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, mag_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        done  <= 1'b0;
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        quo   <= mag_a_in;
        mag_b <= mag_b_in;
        neg   <= req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
      end else if (busy) begin
        if (!diff[WORD_W]) begin
          rem <= diff[WORD_W-1:0];
          quo <= {quo[WORD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[WORD_W-1:0];
          quo <= {quo[WORD_W-2:0], 1'b0};
        end
        cnt  <= cnt + CNT_W'(1);
        done <= (cnt == LAST);
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? (WORD_W'(0) - quo) : quo;

endmodule

`default_nettype wire

// ===== rtl/stack_machine_alu_top.sv =====
// ----------------------------------------------------------------------------
// stack_machine_alu_top
// operand stack and arithmetic unit of a small stack machine
// ----------------------------------------------------------------------------
// Each input beat is a push of a signed 32-bit word or one instruction (pop,
// add, sub, mul, div, mov); each produces exactly one result beat with status,
// popped word, stack depth and program counter. The operand stack lives in a
// synchronous memory with a registered read port; binary operations read the
// two top entries one after the other, compute, and write the result back.
// The block works on one item at a time: push, mov, unknown codes and all
// underflow cases go straight to done, pop reads the top word, add/sub/mul
// do two reads, execute and write back, and div waits for the divider unless
// the divisor is zero. A new item is taken while a finished result still
// waits in the output register; its result is held until that register
// frees up. Because an item only reads the memory after the previous item
// has written it back, no read can overlap a pending write to the same entry.
`default_nettype none

module stack_machine_alu_top #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire sma_pkg::cmd_t                    command,
  input  wire sma_pkg::word_t                   push_value,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output sma_pkg::status_t                      status,
  output sma_pkg::word_t                        popped_value,
  output logic                                  popped_valid,
  output logic [$clog2(STACK_DEPTH+1)-1:0]      stack_depth,
  output logic [31:0]                           program_counter
);
  import sma_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an input beat
  localparam logic [2:0] S_POP  = 3'd1;  // top word arrives from memory
  localparam logic [2:0] S_RD_B = 3'd2;  // top word arrives, next-to-top issued
  localparam logic [2:0] S_RD_A = 3'd3;  // next-to-top arrives
  localparam logic [2:0] S_EXEC = 3'd4;  // add/sub/mul, or start the divider
  localparam logic [2:0] S_DIV  = 3'd5;  // divider running
  localparam logic [2:0] S_WB   = 3'd6;  // write result back on the stack
  localparam logic [2:0] S_DONE = 3'd7;  // hand result to the output register

  logic [2:0]    state;
  cmd_t          op;
  word_t         opa;
  word_t         opb;
  word_t         res_word;
  status_t       res_status;
  word_t         res_popped;
  logic          res_pvalid;
  logic [DW-1:0] depth;
  logic [DW-1:0] depth_m1;
  logic [DW-1:0] depth_m2;
  logic [31:0]   pc;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic [AW-1:0] mem_raddr;
  word_t         mem_rdata;

  div_req_t      div_req;
  div_rsp_t      div_rsp;

  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);
  assign in_ready = (state == S_IDLE);

  // top of stack is read speculatively while idle, so it is there for a pop
  // or for the first operand of a binary op in the cycle after the beat is taken
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = depth[AW-1:0];
    mem_wdata = push_value;
    mem_raddr = depth_m1[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid && command == CMD_PUSH && depth != FULL) begin
          mem_we = 1'b1;
        end
      end
      S_RD_B: begin
        mem_raddr = depth_m2[AW-1:0];
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = depth_m2[AW-1:0];
        mem_wdata = res_word;
      end
      default: begin
      end
    endcase
  end

  sma_stack_mem #(
    .DEPTH (STACK_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign div_req.start    = (state == S_EXEC) && (op == CMD_DIV) && (opb != '0);
  assign div_req.dividend = opa;
  assign div_req.divisor  = opb;

  sma_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      // a result beat leaves; the done state refills the register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op         <= command;
            res_popped <= '0;
            res_pvalid <= 1'b0;
            unique case (command) inside
              CMD_PUSH: begin
                // push is data and leaves the counter alone
                if (depth == FULL) begin
                  res_status <= ST_OVERFLOW;
                end else begin
                  res_status <= ST_OK;
                  depth      <= depth + DW'(1);
                end
                state <= S_DONE;
              end
              CMD_POP, CMD_MOV: begin
                pc <= pc + 32'd1;
                if (depth == '0) begin
                  res_status <= ST_UNDERFLOW;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= (command == CMD_POP) ? S_POP : S_DONE;
                end
              end
              CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                pc <= pc + 32'd1;
                if (depth == '0) begin
                  res_status <= ST_UNDERFLOW;
                  state      <= S_DONE;
                end else if (depth == DW'(1)) begin
                  // lone operand is consumed
                  depth      <= '0;
                  res_status <= ST_UNDERFLOW;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_RD_B;
                end
              end
              default: begin
                res_status <= ST_UNKNOWN;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_POP: begin
          res_popped <= mem_rdata;
          res_pvalid <= 1'b1;
          depth      <= depth_m1;
          state      <= S_DONE;
        end
        S_RD_B: begin
          opb   <= mem_rdata;
          state <= S_RD_A;
        end
        S_RD_A: begin
          opa   <= mem_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          unique case (op)
            CMD_ADD: begin
              res_word <= opa + opb;
              state    <= S_WB;
            end
            CMD_SUB: begin
              res_word <= opa - opb;
              state    <= S_WB;
            end
            CMD_MUL: begin
              res_word <= opa * opb;
              state    <= S_WB;
            end
            CMD_DIV: begin
              if (opb == '0) begin
                // both operands dropped, nothing pushed
                res_status <= ST_DIVZERO;
                depth      <= depth_m2;
                state      <= S_DONE;
              end else begin
                state <= S_DIV;
              end
            end
            default: begin
              res_word <= '0;
              state    <= S_WB;
            end
          endcase
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_word <= div_rsp.quotient;
            state    <= S_WB;
          end
        end
        S_WB: begin
          // two popped, one pushed
          depth <= depth_m1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            popped_value    <= res_popped;
            popped_valid    <= res_pvalid;
            stack_depth     <= depth;
            program_counter <= pc;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sma_checker.sv =====
// ----------------------------------------------------------------------------
// sma_checker
// port-level checks on the result channel of the stack machine alu
// ----------------------------------------------------------------------------
`default_nettype none

module sma_checker #(
  parameter int STACK_DEPTH = 64
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire sma_pkg::status_t                 status,
  input wire sma_pkg::word_t                   popped_value,
  input wire logic                             popped_valid,
  input wire logic [$clog2(STACK_DEPTH+1)-1:0] stack_depth
);
  import sma_pkg::*;

  localparam logic [$clog2(STACK_DEPTH+1)-1:0] FULL = ($clog2(STACK_DEPTH+1))'(STACK_DEPTH);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(stack_depth))
    else $error("result beat changed while stalled");

  // depth never exceeds the stack size
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stack_depth <= FULL)
    else $error("stack depth out of range");

  // a popped word only comes with ok status, otherwise the word is zero
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && popped_valid |-> status == ST_OK)
    else $error("popped word with error status");

  a_pop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !popped_valid |-> popped_value == '0)
    else $error("nonzero popped value without pop");

  // overflow only when the stack is full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OVERFLOW |-> stack_depth == FULL)
    else $error("overflow reported below full depth");

endmodule

bind stack_machine_alu_top sma_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .popped_value (popped_value),
  .popped_valid (popped_valid),
  .stack_depth  (stack_depth)
);

`default_nettype wire

// ===== tb/stack_machine_alu_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_machine_alu_top_tb
// self-checking bench for the stack machine alu
// ----------------------------------------------------------------------------
// Every accepted input beat is run through a local copy of the operand stack,
// depth and program counter, and the outcome is queued. Each accepted result
// beat is checked field by field against the oldest queued outcome. A short
// table of directed beats comes first, then random traffic in three phases
// with different idle patterns on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_alu_top_tb;

  import sma_pkg::*;

  localparam int STACK_WORDS = 64;
  localparam int DEPTH_W     = $clog2(STACK_WORDS + 1);

  // one result beat as seen on the output channel
  typedef struct packed {
    status_t            status;
    word_t              popped_value;
    logic               popped_valid;
    logic [DEPTH_W-1:0] stack_depth;
    logic [31:0]        program_counter;
  } alu_result_t;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct packed {
    cmd_t        cmd;
    word_t       value;
    logic        typed;
    alu_result_t result;
  } directed_row_t;

  localparam alu_result_t NO_RESULT = '0;

  // starts from the reset state: empty stack, counter at zero
  localparam directed_row_t DIRECTED_ROWS [25] = '{
    // underflow on an empty stack, counter still moves
    '{CMD_POP,     32'sd0,          1'b1, '{ST_UNDERFLOW, 32'sd0, 1'b0, 7'd0, 32'd1}},
    '{CMD_ADD,     32'sd0,          1'b1, '{ST_UNDERFLOW, 32'sd0, 1'b0, 7'd0, 32'd2}},
    '{CMD_MOV,     32'sd0,          1'b1, '{ST_UNDERFLOW, 32'sd0, 1'b0, 7'd0, 32'd3}},
    // unknown code leaves the counter alone
    '{CMD_UNKNOWN, 32'sd0,          1'b1, '{ST_UNKNOWN,   32'sd0, 1'b0, 7'd0, 32'd3}},
    // binary op with a single word consumes it
    '{CMD_PUSH,    32'sh7fffffff,   1'b1, '{ST_OK,        32'sd0, 1'b0, 7'd1, 32'd3}},
    '{CMD_SUB,     32'sd0,          1'b1, '{ST_UNDERFLOW, 32'sd0, 1'b0, 7'd0, 32'd4}},
    // most negative word over minus one wraps back to itself
    '{CMD_PUSH,    32'sh80000000,   1'b1, '{ST_OK,        32'sd0, 1'b0, 7'd1, 32'd4}},
    '{CMD_PUSH,    32'shffffffff,   1'b1, '{ST_OK,        32'sd0, 1'b0, 7'd2, 32'd4}},
    '{CMD_DIV,     32'sd0,          1'b1, '{ST_OK,        32'sd0, 1'b0, 7'd1, 32'd5}},
    '{CMD_POP,     32'sd0,          1'b1,
      '{ST_OK, 32'sh80000000, 1'b1, 7'd0, 32'd6}},
    // divide by zero drops both operands
    '{CMD_PUSH,    32'sd7,          1'b1, '{ST_OK,        32'sd0, 1'b0, 7'd1, 32'd6}},
    '{CMD_PUSH,    32'sd0,          1'b1, '{ST_OK,        32'sd0, 1'b0, 7'd2, 32'd6}},
    '{CMD_DIV,     32'sd0,          1'b1, '{ST_DIVZERO,   32'sd0, 1'b0, 7'd0, 32'd7}},
    // the rest goes through the predictor
    '{CMD_PUSH,    -32'sd7,         1'b0, NO_RESULT},
    '{CMD_PUSH,    32'sd2,          1'b0, NO_RESULT},
    '{CMD_DIV,     32'sh12345678,   1'b0, NO_RESULT},
    '{CMD_MOV,     32'shffffffff,   1'b0, NO_RESULT},
    '{CMD_PUSH,    32'sh7fffffff,   1'b0, NO_RESULT},
    '{CMD_ADD,     32'sd0,          1'b0, NO_RESULT},
    '{CMD_PUSH,    32'sh80000000,   1'b0, NO_RESULT},
    '{CMD_MUL,     32'sd0,          1'b0, NO_RESULT},
    '{CMD_PUSH,    32'sd5,          1'b0, NO_RESULT},
    '{CMD_SUB,     32'sd0,          1'b0, NO_RESULT},
    '{CMD_POP,     32'sd0,          1'b0, NO_RESULT},
    '{CMD_POP,     32'sh5a5a5a5a,   1'b0, NO_RESULT}
  };

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic  in_valid   = 1'b0;
  logic  in_ready;
  cmd_t  command    = CMD_PUSH;
  word_t push_value = '0;

  // result channel
  logic               out_valid;
  logic               out_ready = 1'b0;
  status_t            status;
  word_t              popped_value;
  logic               popped_valid;
  logic [DEPTH_W-1:0] stack_depth;
  logic [31:0]        program_counter;

  // idle shaping, in percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // long receiver hold-off, requested by the stimulus and counted below
  bit          hold_off_req = 1'b0;
  int unsigned hold_left    = 0;

  int unsigned error_count = 0;

  // predictor state: operand stack, depth and program counter
  word_t       model_stack [STACK_WORDS];
  int unsigned model_depth = 0;
  logic [31:0] model_pc    = '0;

  // outcomes waiting for their result beat, oldest first
  alu_result_t expected_results [$];

  always #2 clk = ~clk;

  stack_machine_alu_top #(
    .STACK_DEPTH(STACK_WORDS)
  ) uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .push_value      (push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .popped_value    (popped_value),
    .popped_valid    (popped_valid),
    .stack_depth     (stack_depth),
    .program_counter (program_counter)
  );

  // ---------------------------------------------------------------------------
  // predictor: applies one accepted beat to the local stack and returns the
  // result beat it must produce
  // ---------------------------------------------------------------------------
  function automatic alu_result_t execute_instr(cmd_t cmd, word_t val);
    alu_result_t r;
    word_t       lhs;
    word_t       rhs;
    word_t       res;
    logic [31:0] mag_l;
    logic [31:0] mag_r;
    logic [31:0] quo;
    r        = '0;
    r.status = ST_OK;
    res      = '0;
    case (cmd)
      CMD_PUSH: begin
        // a push is data, so the counter stays put
        if (model_depth >= STACK_WORDS) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_stack[model_depth] = val;
          model_depth++;
        end
      end
      CMD_POP, CMD_MOV: begin
        // mov takes the top word off and puts it back: no visible change
        if (model_depth == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (cmd == CMD_POP) begin
          model_depth--;
          r.popped_value = model_stack[model_depth];
          r.popped_valid = 1'b1;
        end
        model_pc++;
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (model_depth < 2) begin
          // a lone word is consumed, an empty stack stays empty
          r.status    = ST_UNDERFLOW;
          model_depth = 0;
        end else begin
          rhs = model_stack[model_depth - 1];
          lhs = model_stack[model_depth - 2];
          model_depth -= 2;
          case (cmd)
            CMD_ADD: res = lhs + rhs;
            CMD_SUB: res = lhs - rhs;
            CMD_MUL: res = lhs * rhs;
            default: begin
              if (rhs == 0) begin
                r.status = ST_DIVZERO;
              end else begin
                // divide magnitudes, then fix the sign: truncates toward zero
                mag_l = lhs[31] ? -lhs : lhs;
                mag_r = rhs[31] ? -rhs : rhs;
                quo   = mag_l / mag_r;
                res   = (lhs[31] ^ rhs[31]) ? -quo : quo;
              end
            end
          endcase
          if (r.status == ST_OK) begin
            model_stack[model_depth] = res;
            model_depth++;
          end
        end
        model_pc++;
      end
      default: r.status = ST_UNKNOWN;
    endcase
    r.stack_depth     = DEPTH_W'(model_depth);
    r.program_counter = model_pc;
    return r;
  endfunction

  // push words: half full range, plenty of small ones so that zero divisors
  // and exact quotients show up, and the corner words
  function automatic word_t random_word();
    case ($urandom_range(3))
      0: return word_t'(int'($urandom_range(18)) - 9);
      1: begin
        case ($urandom_range(4))
          0: return 32'sh80000000;
          1: return 32'sh7fffffff;
          2: return -32'sd1;
          3: return 32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return word_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers one beat, waits for the handshake and queues the outcome
  // ---------------------------------------------------------------------------
  task automatic send_beat(cmd_t cmd, word_t val, logic typed, alu_result_t typed_result);
    alu_result_t predicted;
    // random gap before the beat; valid only drops when a gap follows
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    push_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // beat taken at this edge
    predicted = execute_instr(cmd, val);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  // sender pause: nothing offered until every queued outcome has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // random traffic; now and then the stack is pushed past full, which covers
  // overflow and the deep entries, and the ops that follow bring it back down
  task automatic run_random(int unsigned count);
    int unsigned n;
    int unsigned pick;
    cmd_t        cmd;
    for (n = 0; n < count; n++) begin
      if (n % 150 == 75) begin
        repeat (STACK_WORDS - model_depth + 1 + $urandom_range(2))
          send_beat(CMD_PUSH, random_word(), 1'b0, NO_RESULT);
      end
      pick = $urandom_range(99);
      if (pick < 3) begin
        cmd = CMD_UNKNOWN;
      end else if (pick < ((model_depth < 3) ? 60 : 45)) begin
        cmd = CMD_PUSH;
      end else begin
        cmd = cmd_t'($urandom_range(CMD_MOV, CMD_POP));
      end
      // push_value is random on every beat, used or not
      send_beat(cmd, random_word(), 1'b0, NO_RESULT);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: ready pattern, long hold-off and result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    alu_result_t got;
    alu_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{status, popped_value, popped_valid, stack_depth, program_counter};
        if (expected_results.size() == 0) begin
          $error("result beat with no outstanding command");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
          end
          if (got.popped_value !== want.popped_value) begin
            $error("popped_value: expected %0d, got %0d", want.popped_value,
                   got.popped_value);
            error_count++;
          end
          if (got.popped_valid !== want.popped_valid) begin
            $error("popped_valid: expected %0d, got %0d", want.popped_valid,
                   got.popped_valid);
            error_count++;
          end
          if (got.stack_depth !== want.stack_depth) begin
            $error("stack_depth: expected %0d, got %0d", want.stack_depth,
                   got.stack_depth);
            error_count++;
          end
          if (got.program_counter !== want.program_counter) begin
            $error("program_counter: expected %0d, got %0d", want.program_counter,
                   got.program_counter);
            error_count++;
          end
        end
      end
      if (hold_off_req) begin
        hold_left    = 300;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 1: mostly busy sender, slow receiver; directed table from reset
    send_idle_pct  = 27;
    recv_stall_pct = 77;
    foreach (DIRECTED_ROWS[i]) begin
      send_beat(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].result);
    end
    run_random(330);
    drain_results();

    // phase 2: the other way round
    send_idle_pct  = 77;
    recv_stall_pct = 27;
    run_random(330);
    drain_results();

    // phase 3: no idling; receiver blocks for a long stretch at the start so
    // the block backs up and holds off the input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b1;
    run_random(330);
    drain_results();

    // tail: let any stray result beat show up
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("** stack_machine_alu_top: PASSED **");
    end else begin
      $display("** stack_machine_alu_top: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("** stack_machine_alu_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
